FILE: rtl/ps2mh_pkg.sv
// Shared types and constants for the PS/2 mouse host link.
`default_nettype none

package ps2mh_pkg;

    // Item operation codes
    localparam logic OP_EDGE    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Error codes
    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_START  = 3'd1;
    localparam logic [2:0] ERR_PARITY = 3'd2;
    localparam logic [2:0] ERR_STOP   = 3'd3;
    localparam logic [2:0] ERR_ALWAYS = 3'd4;
    localparam logic [2:0] ERR_SIGN   = 3'd5;

    // Frame positions
    localparam logic [3:0] POS_START  = 4'd0;
    localparam logic [3:0] POS_LAST_D = 4'd8;
    localparam logic [3:0] POS_PARITY = 4'd9;
    localparam logic [3:0] POS_STOP   = 4'd10;

    // Packet slots
    localparam logic [1:0] SLOT_HEAD = 2'd0;
    localparam logic [1:0] SLOT_X    = 2'd1;
    localparam logic [1:0] SLOT_Y    = 2'd2;

    // Output queue depth
    localparam logic [1:0] QUEUE_FULL = 2'd2;

    typedef struct packed {
        logic       drive_data;
        logic       drive_enable;
        logic       inhibit_clock;
        logic       sending;
        logic       packet_valid;
        logic [2:0] buttons;
        logic [7:0] move_x;
        logic [7:0] move_y;
        logic       x_overflow;
        logic       y_overflow;
        logic [2:0] error;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/ps2mh_top.sv
// Top level of the PS/2 mouse host link: input register, link core, result queue.
// An accepted word is held in the input register; the link core then computes its result,
// which is pushed into the result queue that drives out_valid. Throughput: one word per cycle
// while the queue is not full; a two-entry result queue lets input words keep flowing under
// output stall until it fills. Reset (rst_n low, asynchronous) clears all control state and empties the queue;
// the three packet byte slots hold no reset and are filled before any check reads them.
`default_nettype none

module ps2_mouse_host_link_top
    import ps2mh_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       op,
    input  wire logic       line_bit,
    input  wire logic [7:0] command_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            drive_data,
    output logic            drive_enable,
    output logic            inhibit_clock,
    output logic            sending,
    output logic            packet_valid,
    output logic [2:0]      buttons,
    output logic [7:0]      move_x,
    output logic [7:0]      move_y,
    output logic            x_overflow,
    output logic            y_overflow,
    output logic [2:0]      error
);

    logic       s1_valid_reg;
    logic       s1_op_reg;
    logic       s1_bit_reg;
    logic [7:0] s1_cmd_reg;
    logic       fire;
    logic       pop;
    logic       q_full;
    logic       q_not_empty;
    logic       accept;
    result_t    res;
    result_t    head;

    assign pop      = q_not_empty && !out_stall;
    assign fire     = s1_valid_reg && (!q_full || pop);
    assign in_stall = s1_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg  <= op;
            s1_bit_reg <= line_bit;
            s1_cmd_reg <= command_byte;
        end
    end

    ps2mh_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .op           (s1_op_reg),
        .line_bit     (s1_bit_reg),
        .command_byte (s1_cmd_reg),
        .res          (res)
    );

    ps2mh_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (res),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (head)
    );

    assign out_valid     = q_not_empty;
    assign drive_data    = head.drive_data;
    assign drive_enable  = head.drive_enable;
    assign inhibit_clock = head.inhibit_clock;
    assign sending       = head.sending;
    assign packet_valid  = head.packet_valid;
    assign buttons       = head.buttons;
    assign move_x        = head.move_x;
    assign move_y        = head.move_y;
    assign x_overflow    = head.x_overflow;
    assign y_overflow    = head.y_overflow;
    assign error         = head.error;

`ifndef SYNTH
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && q_full)
        else $error("input stalled without a held word and a full queue");

    a_request_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
        fire && s1_op_reg == OP_REQUEST |-> res.inhibit_clock && res.sending &&
            res.drive_enable && !res.drive_data)
        else $error("command request did not start a transmit frame");

    a_packet_clean: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.packet_valid |-> res.error == ERR_NONE && !res.sending)
        else $error("packet delivered with an error or during transmit");

    a_full_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
        q_full && out_stall |=> q_full && $stable(head))
        else $error("queue head changed while stalled and full");
`endif

endmodule

`default_nettype wire

FILE: rtl/ps2mh_core.sv
// Link state and per-word receive, packet check and transmit logic.
`default_nettype none

module ps2mh_core
    import ps2mh_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire logic       op,
    input  wire logic       line_bit,
    input  wire logic [7:0] command_byte,
    output result_t         res
);

    logic [3:0] rx_pos_reg, rx_pos_next;
    logic [7:0] rx_shift_reg, rx_shift_next;
    logic [1:0] pkt_pos_reg, pkt_pos_next;
    logic       tx_active_reg, tx_active_next;
    logic [7:0] tx_byte_reg, tx_byte_next;
    logic [3:0] tx_pos_reg, tx_pos_next;
    logic       drv_level_reg, drv_level_next;
    logic       drv_on_reg, drv_on_next;
    logic [7:0] store_reg [3];
    logic       store_we;
    logic [1:0] store_slot;

    logic [1:0] slot;
    logic [7:0] b0;
    logic [7:0] bx;
    logic [7:0] by;

    always_comb
    begin
        rx_pos_next    = rx_pos_reg;
        rx_shift_next  = rx_shift_reg;
        pkt_pos_next   = pkt_pos_reg;
        tx_active_next = tx_active_reg;
        tx_byte_next   = tx_byte_reg;
        tx_pos_next    = tx_pos_reg;
        drv_level_next = drv_level_reg;
        drv_on_next    = drv_on_reg;
        store_we       = 1'b0;
        slot           = (pkt_pos_reg > SLOT_Y) ? SLOT_Y : pkt_pos_reg;
        store_slot     = slot;
        b0             = store_reg[0];
        bx             = store_reg[1];
        by             = rx_shift_reg;
        res            = '0;

        if (op == OP_REQUEST)
        begin
            tx_active_next = 1'b1;
            tx_byte_next   = command_byte;
            tx_pos_next    = 4'd0;
            drv_level_next = 1'b0;
            drv_on_next    = 1'b1;
            rx_pos_next    = POS_START;
            res.inhibit_clock = 1'b1;
        end
        else if (tx_active_reg)
        begin
            priority if (tx_pos_reg <= 4'd7)
            begin
                drv_level_next = tx_byte_reg[tx_pos_reg[2:0]];
                drv_on_next    = 1'b1;
                tx_pos_next    = tx_pos_reg + 4'd1;
            end
            else if (tx_pos_reg == 4'd8)
            begin
                drv_level_next = ~(^tx_byte_reg);
                drv_on_next    = 1'b1;
                tx_pos_next    = tx_pos_reg + 4'd1;
            end
            else if (tx_pos_reg == 4'd9)
            begin
                drv_level_next = 1'b1;
                drv_on_next    = 1'b0;
                tx_pos_next    = tx_pos_reg + 4'd1;
            end
            else
            begin
                // acknowledge edge: release and end the frame
                drv_level_next = 1'b1;
                drv_on_next    = 1'b0;
                tx_active_next = 1'b0;
                tx_byte_next   = 8'd0;
                tx_pos_next    = 4'd0;
            end
        end
        else
        begin
            priority if (rx_pos_reg == POS_START)
            begin
                if (line_bit)
                    res.error = ERR_START;
                else
                    rx_pos_next = 4'd1;
            end
            else if (rx_pos_reg <= POS_LAST_D)
            begin
                rx_shift_next = {line_bit, rx_shift_reg[7:1]};
                rx_pos_next   = rx_pos_reg + 4'd1;
            end
            else if (rx_pos_reg == POS_PARITY)
            begin
                if ((^rx_shift_reg ^ line_bit) != 1'b1)
                begin
                    res.error   = ERR_PARITY;
                    rx_pos_next = POS_START;
                end
                else
                    rx_pos_next = POS_STOP;
            end
            else
            begin
                rx_pos_next = POS_START;
                if (!line_bit)
                    res.error = ERR_STOP;
                else
                begin
                    store_we = 1'b1;
                    if (slot != SLOT_Y)
                        pkt_pos_next = slot + 2'd1;
                    else
                    begin
                        pkt_pos_next = SLOT_HEAD;
                        priority if (!b0[3])
                            res.error = ERR_ALWAYS;
                        else if (bx[7] != b0[4] || by[7] != b0[5])
                            res.error = ERR_SIGN;
                        else
                        begin
                            res.packet_valid = 1'b1;
                            res.buttons      = b0[2:0];
                            res.move_x       = bx;
                            res.move_y       = by;
                            res.x_overflow   = b0[6];
                            res.y_overflow   = b0[7];
                        end
                    end
                end
            end
        end

        res.drive_data   = drv_level_next;
        res.drive_enable = drv_on_next;
        res.sending      = tx_active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_pos_reg    <= POS_START;
            rx_shift_reg  <= 8'd0;
            pkt_pos_reg   <= SLOT_HEAD;
            tx_active_reg <= 1'b0;
            tx_byte_reg   <= 8'd0;
            tx_pos_reg    <= 4'd0;
            drv_level_reg <= 1'b1;
            drv_on_reg    <= 1'b0;
        end
        else if (fire)
        begin
            rx_pos_reg    <= rx_pos_next;
            rx_shift_reg  <= rx_shift_next;
            pkt_pos_reg   <= pkt_pos_next;
            tx_active_reg <= tx_active_next;
            tx_byte_reg   <= tx_byte_next;
            tx_pos_reg    <= tx_pos_next;
            drv_level_reg <= drv_level_next;
            drv_on_reg    <= drv_on_next;
        end
    end

    // packet bytes hold no reset; each slot is written before it is read
    always_ff @(posedge clk)
    begin
        if (fire && store_we)
            store_reg[store_slot] <= rx_shift_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/ps2mh_outq.sv
// Two-entry result queue: output register plus skid slot.
`default_nettype none

module ps2mh_outq
    import ps2mh_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    input  wire logic    pop,
    output logic         full,
    output logic         not_empty,
    output result_t      head
);

    logic [1:0] count_reg, count_next;
    result_t    q0_reg, q0_next;
    result_t    q1_reg, q1_next;

    assign full      = (count_reg == QUEUE_FULL);
    assign not_empty = (count_reg != 2'd0);
    assign head      = q0_reg;

    always_comb
    begin
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        count_next = count_reg;
        unique case ({push, pop})
            2'b11:
            begin
                if (count_reg == 2'd1)
                    q0_next = push_data;
                else
                begin
                    q0_next = q1_reg;
                    q1_next = push_data;
                end
            end
            2'b10:
            begin
                count_next = count_reg + 2'd1;
                if (count_reg == 2'd0)
                    q0_next = push_data;
                else
                    q1_next = push_data;
            end
            2'b01:
            begin
                count_next = count_reg - 2'd1;
                q0_next    = q1_reg;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

`default_nettype wire

FILE: test/tb_ps2mh_link_score_pkg.sv
// Scoreboard class for the PS/2 mouse host link: predicts each result word and checks it.
`timescale 1ns / 100ps

package tb_ps2mh_link_score_pkg;

    import ps2mh_pkg::*;

    class link_scoreboard;

        // Predicted link state
        logic [3:0] rx_pos;
        logic [7:0] rx_byte;
        logic [7:0] pkt_bytes [3];
        logic [1:0] pkt_slot;
        logic       tx_on;
        logic [7:0] tx_data;
        logic [3:0] tx_pos;
        logic       line_level;
        logic       line_driven;

        result_t    expected_words [$];
        int         fails;
        int         seen;

        function new();
            rx_pos      = POS_START;
            rx_byte     = '0;
            pkt_slot    = SLOT_HEAD;
            tx_on       = 1'b0;
            tx_data     = '0;
            tx_pos      = '0;
            line_level  = 1'b1;
            line_driven = 1'b0;
            fails       = 0;
            seen        = 0;
        endfunction

        task report(string msg);
            if (fails < 40)
                $display("mismatch on result word %0d: %s", seen, msg);
            fails++;
        endtask

        // Work out the result word caused by one accepted input word
        function void note_word(logic op_in, logic bit_in, logic [7:0] cmd_in);
            result_t r;
            logic [7:0] b0;
            logic [7:0] bx;
            logic [7:0] by;
            r = '0;
            if (op_in == OP_REQUEST)
            begin
                tx_on         = 1'b1;
                tx_data       = cmd_in;
                tx_pos        = '0;
                line_level    = 1'b0;
                line_driven   = 1'b1;
                rx_pos        = POS_START;
                r.inhibit_clock = 1'b1;
            end
            else if (tx_on)
            begin
                // edges while sending shift out the command and its parity, then release the line; line_bit is ignored
                if (tx_pos < POS_LAST_D)
                begin
                    line_level  = tx_data[tx_pos[2:0]];
                    line_driven = 1'b1;
                    tx_pos      = tx_pos + 4'd1;
                end
                else if (tx_pos == POS_LAST_D)
                begin
                    line_level  = ~^tx_data;
                    line_driven = 1'b1;
                    tx_pos      = tx_pos + 4'd1;
                end
                else if (tx_pos == POS_PARITY)
                begin
                    line_level  = 1'b1;
                    line_driven = 1'b0;
                    tx_pos      = tx_pos + 4'd1;
                end
                else
                begin
                    // acknowledge edge ends the frame
                    line_level  = 1'b1;
                    line_driven = 1'b0;
                    tx_on       = 1'b0;
                    tx_data     = '0;
                    tx_pos      = '0;
                end
            end
            else if (rx_pos == POS_START)
            begin
                if (bit_in)
                    r.error = ERR_START;
                else
                    rx_pos = POS_START + 4'd1;
            end
            else if (rx_pos <= POS_LAST_D)
            begin
                rx_byte = {bit_in, rx_byte[7:1]};
                rx_pos  = rx_pos + 4'd1;
            end
            else if (rx_pos == POS_PARITY)
            begin
                if ((^rx_byte ^ bit_in) != 1'b1)
                begin
                    r.error = ERR_PARITY;
                    rx_pos  = POS_START;
                end
                else
                    rx_pos = POS_STOP;
            end
            else
            begin
                rx_pos = POS_START;
                if (!bit_in)
                    r.error = ERR_STOP;
                else
                begin
                    pkt_bytes[pkt_slot] = rx_byte;
                    if (pkt_slot != SLOT_Y)
                        pkt_slot = pkt_slot + 2'd1;
                    else
                    begin
                        b0       = pkt_bytes[SLOT_HEAD];
                        bx       = pkt_bytes[SLOT_X];
                        by       = pkt_bytes[SLOT_Y];
                        pkt_slot = SLOT_HEAD;
                        if (!b0[3])
                            r.error = ERR_ALWAYS;
                        else if (bx[7] != b0[4] || by[7] != b0[5])
                            r.error = ERR_SIGN;
                        else
                        begin
                            r.packet_valid = 1'b1;
                            r.buttons      = b0[2:0];
                            r.move_x       = bx;
                            r.move_y       = by;
                            r.x_overflow   = b0[6];
                            r.y_overflow   = b0[7];
                        end
                    end
                end
            end
            r.drive_data   = line_level;
            r.drive_enable = line_driven;
            r.sending      = tx_on;
            expected_words.push_back(r);
        endfunction

        task compare_field(string name, int got, int want);
            if (got != want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_word(result_t got);
            result_t want;
            if (expected_words.size() == 0)
            begin
                report("result with nothing expected");
            end
            else
            begin
                want = expected_words.pop_front();
                compare_field("drive_data", got.drive_data, want.drive_data);
                compare_field("drive_enable", got.drive_enable, want.drive_enable);
                compare_field("inhibit_clock", got.inhibit_clock, want.inhibit_clock);
                compare_field("sending", got.sending, want.sending);
                compare_field("packet_valid", got.packet_valid, want.packet_valid);
                compare_field("buttons", got.buttons, want.buttons);
                compare_field("move_x", got.move_x, want.move_x);
                compare_field("move_y", got.move_y, want.move_y);
                compare_field("x_overflow", got.x_overflow, want.x_overflow);
                compare_field("y_overflow", got.y_overflow, want.y_overflow);
                compare_field("error", got.error, want.error);
            end
            seen++;
        endtask

        function int pending();
            return expected_words.size();
        endfunction

    endclass

endpackage

FILE: test/tb_ps2_mouse_host_link_top.sv
// Testbench for the PS/2 mouse host link: directed and random edge/command traffic.
`timescale 1ns / 100ps

module tb_ps2_mouse_host_link_top;

    import ps2mh_pkg::*;
    import tb_ps2mh_link_score_pkg::*;

    localparam int WORDS_TOTAL  = 1350;
    localparam int WORDS_CALM   = 1200;
    localparam int STUCK_LIMIT  = 300;

    typedef enum int {FRAME_OK, FRAME_BAD_PARITY, FRAME_BAD_STOP} frame_fault_t;
    typedef enum int {PKT_GOOD, PKT_NO_ALWAYS_ONE, PKT_SIGN_X, PKT_SIGN_Y} pkt_kind_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       op = OP_EDGE;
    logic       line_bit = 1'b1;
    logic [7:0] command_byte = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       drive_data;
    logic       drive_enable;
    logic       inhibit_clock;
    logic       sending;
    logic       packet_valid;
    logic [2:0] buttons;
    logic [7:0] move_x;
    logic [7:0] move_y;
    logic       x_overflow;
    logic       y_overflow;
    logic [2:0] error;

    result_t        seen_word;
    link_scoreboard board = new();
    int             words_sent = 0;
    bit             gaps_on = 1'b1;
    bit             stalls_on = 1'b1;
    int             stall_left = 0;
    int             stuck_cycles = 0;

    ps2_mouse_host_link_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .line_bit     (line_bit),
        .command_byte (command_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .drive_data   (drive_data),
        .drive_enable (drive_enable),
        .inhibit_clock(inhibit_clock),
        .sending      (sending),
        .packet_valid (packet_valid),
        .buttons      (buttons),
        .move_x       (move_x),
        .move_y       (move_y),
        .x_overflow   (x_overflow),
        .y_overflow   (y_overflow),
        .error        (error)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    assign seen_word = {drive_data, drive_enable, inhibit_clock, sending, packet_valid,
                        buttons, move_x, move_y, x_overflow, y_overflow, error};

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_word(seen_word);
    end

    // Output stall in random bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (rst_n && stalls_on && $urandom_range(0, 9) == 0)
        begin
            stall_left <= $urandom_range(0, 5);
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles <= 0;
            else if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    task drive_word(logic op_v, logic bit_v, logic [7:0] cmd_v);
        if (gaps_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= op_v;
        line_bit     <= bit_v;
        command_byte <= cmd_v;
        do
            @(posedge clk);
        while (in_stall);
        board.note_word(op_v, bit_v, cmd_v);
        words_sent++;
    endtask

    task clock_edge(logic bit_v);
        drive_word(OP_EDGE, bit_v, 8'($urandom));
    endtask

    // Hold the sender off until every expected word has come back
    task drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task send_host_command(logic [7:0] cmd, int edges);
        drive_word(OP_REQUEST, 1'($urandom), cmd);
        repeat (edges) clock_edge(1'($urandom));
    endtask

    task send_device_byte(logic [7:0] value, frame_fault_t fault);
        clock_edge(1'b0);
        for (int i = 0; i < 8; i++)
            clock_edge(value[i]);
        clock_edge(fault == FRAME_BAD_PARITY ? ^value : ~^value);
        clock_edge(fault != FRAME_BAD_STOP);
    endtask

    // Send a three-byte packet; retry_slot names a byte first sent with a framing fault
    task send_mouse_packet(pkt_kind_t kind, int retry_slot);
        logic [7:0] pkt [3];
        pkt[SLOT_HEAD]    = 8'($urandom);
        pkt[SLOT_X]       = 8'($urandom);
        pkt[SLOT_Y]       = 8'($urandom);
        pkt[SLOT_HEAD][3] = (kind != PKT_NO_ALWAYS_ONE);
        pkt[SLOT_HEAD][4] = pkt[SLOT_X][7] ^ (kind == PKT_SIGN_X);
        pkt[SLOT_HEAD][5] = pkt[SLOT_Y][7] ^ (kind == PKT_SIGN_Y);
        if (kind == PKT_NO_ALWAYS_ONE && $urandom_range(0, 1) == 1)
            pkt[SLOT_HEAD][4] = ~pkt[SLOT_HEAD][4];
        for (int s = 0; s < 3; s++)
        begin
            if (s == retry_slot)
                send_device_byte(pkt[s], $urandom_range(0, 1) ? FRAME_BAD_PARITY
                                                              : FRAME_BAD_STOP);
            send_device_byte(pkt[s], FRAME_OK);
        end
    endtask

    initial
    begin
        int pick;
        bit drained_once;
        drained_once = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // start bit high, then a receive frame cut short by a command
        clock_edge(1'b1);
        clock_edge(1'b0);
        clock_edge(1'b1);
        clock_edge(1'b0);
        clock_edge(1'b1);
        drive_word(OP_REQUEST, 1'b1, 8'h00);
        // restart the command while it is still going out
        repeat (3) clock_edge(1'b1);
        send_host_command(8'hFF, 11);
        clock_edge(1'b1);

        while (words_sent < WORDS_TOTAL)
        begin
            if (words_sent >= WORDS_CALM)
            begin
                gaps_on   = 1'b0;
                stalls_on = 1'b0;
            end
            if (!drained_once && words_sent >= WORDS_TOTAL / 2)
            begin
                drain();
                drained_once = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_mouse_packet(PKT_GOOD, -1);
            else if (pick < 55)
                send_mouse_packet(PKT_GOOD, $urandom_range(0, 2));
            else if (pick < 63)
                send_mouse_packet(PKT_NO_ALWAYS_ONE, -1);
            else if (pick < 71)
                send_mouse_packet($urandom_range(0, 1) ? PKT_SIGN_X : PKT_SIGN_Y, -1);
            else if (pick < 81)
                send_host_command(8'($urandom), 11);
            else if (pick < 87)
            begin
                send_host_command(8'($urandom), $urandom_range(0, 10));
                send_host_command(8'($urandom), 11);
            end
            else if (pick < 93)
            begin
                // partial receive frame, aborted by the command
                clock_edge(1'b0);
                repeat ($urandom_range(0, 9)) clock_edge(1'($urandom));
                send_host_command(8'($urandom), 11);
            end
            else
            begin
                repeat ($urandom_range(1, 6)) clock_edge(1'($urandom));
                send_host_command(8'($urandom), 11);
            end
        end

        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.fails == 0 && board.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
